FILE: hdl/rbmf_pkg.sv
package rbmf_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_RADIUS  = 7;
	localparam int SAMPLE_BITS = 32;
	localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
	localparam int MAX_OUT     = 8;
	localparam int COL_BITS    = 10;
	localparam int ROW_BITS    = 16;
	localparam int RM_BITS     = 4;
	localparam int ADDR_BITS   = RM_BITS + COL_BITS;
	localparam int SUM_BITS    = 40;
	localparam int CNT_BITS    = 8;
	localparam int DIV_STEPS   = SUM_BITS;

	typedef enum logic [2:0] {
		REG_RADIUS   = 3'd0,
		REG_WIDTH    = 3'd1,
		REG_HEIGHT   = 3'd2,
		REG_ND_EN    = 3'd3,
		REG_ND_VALUE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]         kernel_radius;
		logic [10:0]        image_width;
		logic [15:0]        image_height;
		logic               nodata_enable;
		logic signed [31:0] nodata_value;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic wrap;
		logic store;
		logic run_clr;
		logic win_init;
		logic rd_centre;
		logic set_nd;
		logic acc;
		logic div_start;
		logic div_step;
		logic div_take;
		logic adv;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic is_drain;
		logic in_full;
		logic more_ok;
		logic centre_nd;
		logic el_last;
		logic div_done;
	} sts_t;

	function automatic logic [RM_BITS-1:0] next_mod(input logic [RM_BITS-1:0] m);
		next_mod = (m == RM_BITS'(STORE_ROWS - 1)) ? '0 : m + 1'b1;
	endfunction

endpackage

FILE: hdl/rbmf_ctrl.sv
module rbmf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  rbmf_pkg::sts_t  sts,
	output rbmf_pkg::cmd_t  cmd
);
	import rbmf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_WRAP, S_ACT, S_CHECK, S_CCHK, S_ERD, S_EACC,
		S_DVS, S_DIV, S_ADV, S_EVAL, S_EMIT
	} state_t;

	state_t state_q;
	logic   more_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			more_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_WRAP;
				S_WRAP:  state_q <= S_ACT;
				S_ACT: begin
					if (sts.is_drain) state_q <= sts.in_full ? S_CHECK : S_IDLE;
					else state_q <= sts.in_full ? S_IDLE : S_CHECK;
				end
				S_CHECK: state_q <= sts.more_ok ? S_CCHK : S_IDLE;
				S_CCHK:  state_q <= sts.centre_nd ? S_ADV : S_ERD;
				S_ERD:   state_q <= S_EACC;
				S_EACC:  state_q <= sts.el_last ? S_DVS : S_ERD;
				S_DVS:   state_q <= S_DIV;
				S_DIV:   if (sts.div_done) state_q <= S_ADV;
				S_ADV:   state_q <= S_EVAL;
				S_EVAL: begin
					more_q  <= sts.more_ok;
					state_q <= S_EMIT;
				end
				S_EMIT:  if (out_ready) state_q <= more_q ? S_CHECK : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.wrap      = (state_q == S_WRAP);
		cmd.store     = (state_q == S_ACT) && !sts.is_drain && !sts.in_full;
		cmd.run_clr   = (state_q == S_ACT);
		cmd.win_init  = (state_q == S_CHECK);
		cmd.rd_centre = (state_q == S_CHECK);
		cmd.set_nd    = (state_q == S_CCHK) && sts.centre_nd;
		cmd.acc       = (state_q == S_EACC);
		cmd.div_start = (state_q == S_DVS);
		cmd.div_step  = (state_q == S_DIV) && !sts.div_done;
		cmd.div_take  = (state_q == S_DIV) && sts.div_done;
		cmd.adv       = (state_q == S_ADV);
		cmd.emit_load = (state_q == S_EVAL);
	end

endmodule

FILE: hdl/rbmf_dp.sv
module rbmf_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rbmf_pkg::cfg_t      cfg,
	input  rbmf_pkg::cmd_t      cmd,
	output rbmf_pkg::sts_t      sts,
	input  logic                in_cmd,
	input  logic signed [31:0]  in_sample,
	output logic signed [31:0]  mean_value,
	output logic                last_of_run,
	output logic                last_of_frame
);
	import rbmf_pkg::*;

	logic [10:0]         w_eff;
	logic [15:0]         h_eff;
	logic [2:0]          rad;

	logic                cmd_q;
	logic [31:0]         smp_q;
	logic [ROW_BITS-1:0] in_row_q, out_row_q;
	logic [COL_BITS-1:0] in_col_q, out_col_q;
	logic [RM_BITS-1:0]  in_rm_q, out_rm_q;
	logic [3:0]          n_q;

	logic [31:0]         mem [0:STORE_ROWS*MAX_WIDTH-1];
	logic [31:0]         rdata_q;
	logic [ADDR_BITS-1:0] rd_addr, wr_addr;

	logic [ROW_BITS-1:0] rr_q, bot_q;
	logic [RM_BITS-1:0]  rm_q;
	logic [COL_BITS-1:0] cc_q, lft_q, rgt_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic [SUM_BITS-1:0] dv_q;
	logic [CNT_BITS-1:0] rem_q, den_q;
	logic [5:0]          dcnt_q;
	logic                neg_q;

	logic signed [31:0]  res_q;
	logic                lor_q, lof_q;

	// window geometry from the current output position
	logic [ROW_BITS-1:0] top, bot;
	logic [16:0]         bot_sum;
	logic [COL_BITS-1:0] lft, rgt;
	logic [10:0]         rgt_sum;
	logic [2:0]          dtop;
	logic [4:0]          top_mod5;
	logic                ready, out_last, rd_nd;
	logic [8:0]          sh;
	logic [SUM_BITS-1:0] qv;

	assign w_eff = (cfg.image_width == 11'd0) ? 11'd1 :
		(cfg.image_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : cfg.image_width;
	assign h_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
	assign rad   = cfg.kernel_radius;

	always_comb begin
		top      = (out_row_q >= {13'd0, rad}) ? out_row_q - {13'd0, rad} : '0;
		dtop     = 3'(out_row_q - top);
		top_mod5 = ({1'b0, out_rm_q} >= {2'b0, dtop}) ? {1'b0, out_rm_q} - {2'b0, dtop}
			: {1'b0, out_rm_q} + 5'(STORE_ROWS) - {2'b0, dtop};
		bot_sum  = {1'b0, out_row_q} + {14'd0, rad};
		bot      = (bot_sum < {1'b0, h_eff}) ? bot_sum[15:0] : h_eff - 16'd1;
		lft      = (out_col_q >= {7'd0, rad}) ? out_col_q - {7'd0, rad} : '0;
		rgt_sum  = {1'b0, out_col_q} + {8'd0, rad};
		rgt      = (rgt_sum < w_eff) ? rgt_sum[9:0] : 10'(w_eff - 11'd1);
		ready    = (in_row_q > bot) || ((in_row_q == bot) && (in_col_q > rgt));
		out_last = (out_row_q == h_eff - 16'd1) && ({1'b0, out_col_q} == w_eff - 11'd1);
		rd_nd    = cfg.nodata_enable && (rdata_q == cfg.nodata_value);
		sh       = {rem_q, dv_q[SUM_BITS-1]};
		qv       = neg_q ? (~dv_q + 1'b1) : dv_q;
	end

	assign sts.is_drain  = cmd_q;
	assign sts.in_full   = (in_row_q >= h_eff);
	assign sts.more_ok   = (n_q < 4'(MAX_OUT)) && (out_row_q < h_eff) && ready;
	assign sts.centre_nd = rd_nd;
	assign sts.el_last   = (rr_q == bot_q) && (cc_q == rgt_q);
	assign sts.div_done  = (dcnt_q == 6'd0);

	assign rd_addr = cmd.rd_centre ? {out_rm_q, out_col_q} : {rm_q, cc_q};
	assign wr_addr = {in_rm_q, in_col_q};

	always_ff @(posedge clk) begin
		if (cmd.store) mem[wr_addr] <= smp_q;
		rdata_q <= mem[rd_addr];
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		logic [16:0] orn;
		logic        icw, ocw;
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			in_rm_q   <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			out_rm_q  <= '0;
			n_q       <= '0;
		end else begin
			icw = ({1'b0, in_col_q} >= w_eff);
			ocw = ({1'b0, out_col_q} >= w_eff);
			orn = {1'b0, out_row_q} + {16'd0, ocw};
			if (cmd.wrap) begin
				if (orn >= {1'b0, h_eff}) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					in_rm_q   <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					out_rm_q  <= '0;
				end else begin
					if (icw) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + 1'b1;
						in_rm_q  <= next_mod(in_rm_q);
					end
					if (ocw) begin
						out_col_q <= '0;
						out_row_q <= orn[15:0];
						out_rm_q  <= next_mod(out_rm_q);
					end
				end
			end
			if (cmd.store) begin
				if ({1'b0, in_col_q} + 11'd1 >= w_eff) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
					in_rm_q  <= next_mod(in_rm_q);
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (cmd.run_clr) n_q <= '0;
			if (cmd.adv) begin
				n_q <= n_q + 1'b1;
				if (out_last) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					in_rm_q   <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					out_rm_q  <= '0;
				end else if ({1'b0, out_col_q} + 11'd1 >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
					out_rm_q  <= next_mod(out_rm_q);
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// window walk, accumulator, divider and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			smp_q <= in_sample;
		end
		if (cmd.win_init) begin
			rr_q  <= top;
			rm_q  <= top_mod5[3:0];
			cc_q  <= lft;
			lft_q <= lft;
			rgt_q <= rgt;
			bot_q <= bot;
			sum_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.acc) begin
			if (!rd_nd) begin
				sum_q <= sum_q + SUM_BITS'(signed'(rdata_q));
				cnt_q <= cnt_q + 1'b1;
			end
			if (cc_q == rgt_q) begin
				cc_q <= lft_q;
				rr_q <= rr_q + 1'b1;
				rm_q <= next_mod(rm_q);
			end else begin
				cc_q <= cc_q + 1'b1;
			end
		end
		if (cmd.div_start) begin
			neg_q  <= sum_q[SUM_BITS-1];
			dv_q   <= sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
			rem_q  <= '0;
			den_q  <= cnt_q;
			dcnt_q <= 6'(DIV_STEPS);
		end
		if (cmd.div_step) begin
			if (sh >= {1'b0, den_q}) begin
				rem_q <= 8'(sh - {1'b0, den_q});
				dv_q  <= {dv_q[SUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= sh[7:0];
				dv_q  <= {dv_q[SUM_BITS-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (cmd.div_take) res_q <= qv[31:0];
		if (cmd.set_nd) res_q <= cfg.nodata_value;
		if (cmd.adv) lof_q <= out_last;
		if (cmd.emit_load) lor_q <= !sts.more_ok;
	end

	assign mean_value    = res_q;
	assign last_of_run   = lor_q;
	assign last_of_frame = lof_q;

endmodule

FILE: hdl/raster_box_mean_filter_nodata_unit.sv
// Sequential box mean: one item at a time, results handed out one per output transfer.
// Item: taken, then positions wrapped and the sample stored; an ignored sample or drain
// ends there, else a check decides whether a result can be made from the window.
// Per result: the window cells ((2R+1)^2 at most, fewer at edges) are read and summed, then
// the 40-step restoring divider is set up and run; a nodata centre skips both.
// Reset (arst_n low, asynchronous) clears positions and control; configuration registers return to
// their defaults; the line store holds no reset value and needs no clearing pass.
module raster_box_mean_filter_nodata_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] mean_value
	output logic        m_tlast,
	output logic        m_tuser,   // [0] last_of_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rbmf_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_radius <= 3'd1;
			cfg_q.image_width   <= 11'd1024;
			cfg_q.image_height  <= 16'd1024;
			cfg_q.nodata_enable <= 1'b0;
			cfg_q.nodata_value  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RADIUS:   cfg_q.kernel_radius <= cfg_data[2:0];
				REG_WIDTH:    cfg_q.image_width   <= cfg_data[10:0];
				REG_HEIGHT:   cfg_q.image_height  <= cfg_data[15:0];
				REG_ND_EN:    cfg_q.nodata_enable <= cfg_data[0];
				REG_ND_VALUE: cfg_q.nodata_value  <= cfg_data;
				default: ;
			endcase
		end
	end

	rbmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rbmf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.in_cmd        (s_tuser),
		.in_sample     (s_tdata),
		.mean_value    (m_tdata),
		.last_of_run   (m_tlast),
		.last_of_frame (m_tuser)
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input taken while a result waits");
	a_frame_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast) else $error("frame end not last of run");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second item taken at once");
`endif

endmodule
